[src/drd_pkg.sv]
// ----------------------------------------------------------------------------
// drd_pkg: shared types and constants of the detection row decoder
// Field widths, configuration register indexes, reset values and the
// bundles that pass between the pipeline stages.
// ----------------------------------------------------------------------------
package drd_pkg;

	// Field widths.
	localparam int VALUE_W  = 24;
	localparam int GAIN_W   = 16;
	localparam int COUNT_W  = 8;
	localparam int CLASS_W  = 7;
	localparam int EDGE_W   = 16;
	localparam int PROD_W   = 2 * VALUE_W;
	localparam int FRAC_W   = 14;
	localparam int MAG_W    = VALUE_W + 1;
	localparam int CPROD_W  = MAG_W + GAIN_W;
	localparam int EPROD_W  = VALUE_W + GAIN_W;
	localparam int CSHIFT   = 27;
	localparam int ESHIFT   = 26;
	localparam int OUT_W    = 96;

	// Parameter defaults.
	localparam int MAX_CLASSES_DEF = 128;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = VALUE_W;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CLASS_COUNT    = 2'd0,
		CFG_CONF_THRESHOLD = 2'd1,
		CFG_INV_GAIN       = 2'd2
	} cfg_index_t;

	localparam logic [COUNT_W-1:0] CLASS_COUNT_RST    = 8'd80;
	localparam logic [VALUE_W-1:0] CONF_THRESHOLD_RST = 24'd4096;
	localparam logic [GAIN_W-1:0]  INV_GAIN_RST       = 16'd4096;

	// Row layout: four box values, then objectness, then class scores.
	localparam int BOX_FIELDS = 4;
	localparam int OBJ_POS    = 4;
	localparam int CLASS_POS  = 5;

	// Saturation limits of the output fields.
	localparam logic [16:0] EDGE_POS_MAX = 17'd32767;
	localparam logic [16:0] EDGE_NEG_MAX = 17'd32768;
	localparam logic [16:0] SIZE_MAX     = 17'd65535;

	// Class value on its way from the front stage to the ranking stage.
	typedef struct packed {
		logic               valid;
		logic               first;
		logic               last;
		logic               passes;
		logic [CLASS_W-1:0] class_idx;
		logic [PROD_W-1:0]  prod;
		logic               neg_x;
		logic               neg_y;
		logic [MAG_W-1:0]   mag_x;
		logic [MAG_W-1:0]   mag_y;
		logic [VALUE_W-1:0] size_w;
		logic [VALUE_W-1:0] size_h;
	} rank_s2_t;

	// Decoded box on its way to the output stage.
	typedef struct packed {
		logic               result;
		logic               neg_x;
		logic               neg_y;
		logic [CPROD_W-1:0] prod_x;
		logic [CPROD_W-1:0] prod_y;
		logic [EPROD_W-1:0] prod_w;
		logic [EPROD_W-1:0] prod_h;
		logic [VALUE_W-1:0] score;
		logic [CLASS_W-1:0] class_idx;
	} box_s3_t;

endpackage

[src/drd_front.sv]
// ----------------------------------------------------------------------------
// drd_front: input register, row position tracking and score product
// Places each value in its row, keeps the box values and objectness of the
// current row, and multiplies each class score by the objectness.
// ----------------------------------------------------------------------------
module drd_front #(
	parameter int MAX_CLASSES = drd_pkg::MAX_CLASSES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic                              in_valid,
	input  logic [drd_pkg::VALUE_W-1:0]       in_value,
	input  logic [drd_pkg::COUNT_W-1:0]       class_count,
	input  logic [drd_pkg::VALUE_W-1:0]       conf_threshold,
	output drd_pkg::rank_s2_t                 rank_s2
);

	localparam int POS_W = $clog2(MAX_CLASSES + drd_pkg::CLASS_POS + 1);

	logic                        valid_s1;
	logic [drd_pkg::VALUE_W-1:0] value_s1;
	logic [POS_W-1:0]            pos_q;
	logic [drd_pkg::VALUE_W-1:0] box_q [drd_pkg::BOX_FIELDS];
	logic [drd_pkg::VALUE_W-1:0] obj_q;
	logic                        passes_q;

	logic [POS_W-1:0]            used;
	logic [POS_W-1:0]            idx;
	logic                        is_box;
	logic                        is_obj;
	logic                        last;
	logic [drd_pkg::MAG_W-1:0]   twice_x;
	logic [drd_pkg::MAG_W-1:0]   twice_y;
	logic                        neg_x;
	logic                        neg_y;
	logic [drd_pkg::MAG_W-1:0]   mag_x;
	logic [drd_pkg::MAG_W-1:0]   mag_y;

	// Input register; it moves whenever the pipeline moves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			value_s1 <= in_value;
		end
	end

	// Class count clamped to 1..MAX_CLASSES, and the place of this value.
	always_comb begin
		if (class_count == '0) begin
			used = POS_W'(1);
		end else if (32'(class_count) > 32'(MAX_CLASSES)) begin
			used = POS_W'(MAX_CLASSES);
		end else begin
			used = POS_W'(class_count);
		end
		is_box = pos_q < POS_W'(drd_pkg::OBJ_POS);
		is_obj = pos_q == POS_W'(drd_pkg::OBJ_POS);
		idx    = pos_q - POS_W'(drd_pkg::CLASS_POS);
		last   = ({1'b0, idx} + (POS_W+1)'(1)) >= {1'b0, used};
	end

	// Corner terms 2*c - s as sign and magnitude.
	always_comb begin
		twice_x = {box_q[0], 1'b0};
		twice_y = {box_q[1], 1'b0};
		neg_x   = {1'b0, box_q[2]} > twice_x;
		neg_y   = {1'b0, box_q[3]} > twice_y;
		mag_x   = neg_x ? ({1'b0, box_q[2]} - twice_x) : (twice_x - {1'b0, box_q[2]});
		mag_y   = neg_y ? ({1'b0, box_q[3]} - twice_y) : (twice_y - {1'b0, box_q[3]});
	end

	// Row state: position, box values, objectness and its threshold test.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			obj_q    <= '0;
			passes_q <= 1'b0;
			for (int i = 0; i < drd_pkg::BOX_FIELDS; i++) begin
				box_q[i] <= '0;
			end
		end else if (advance && valid_s1) begin
			if (is_box) begin
				box_q[pos_q[1:0]] <= value_s1;
				pos_q             <= pos_q + POS_W'(1);
			end else if (is_obj) begin
				obj_q    <= value_s1;
				passes_q <= value_s1 > conf_threshold;
				pos_q    <= POS_W'(drd_pkg::CLASS_POS);
			end else if (last) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// Stage 2 register: valid flag, product and snapshot of the row's box.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_s2 <= '0;
		end else if (advance) begin
			rank_s2.valid     <= valid_s1 && !is_box && !is_obj;
			rank_s2.first     <= idx == '0;
			rank_s2.last      <= last;
			rank_s2.passes    <= passes_q;
			rank_s2.class_idx <= drd_pkg::CLASS_W'(idx);
			rank_s2.prod      <= drd_pkg::PROD_W'(value_s1) * drd_pkg::PROD_W'(obj_q);
			rank_s2.neg_x     <= neg_x;
			rank_s2.neg_y     <= neg_y;
			rank_s2.mag_x     <= mag_x;
			rank_s2.mag_y     <= mag_y;
			rank_s2.size_w    <= box_q[2];
			rank_s2.size_h    <= box_q[3];
		end
	end

endmodule

[src/drd_rank.sv]
// ----------------------------------------------------------------------------
// drd_rank: running argmax, row decision and box scaling products
// Keeps the first maximum of the class products and, at the end of a row,
// decides whether a box leaves and multiplies its terms by the gain.
// ----------------------------------------------------------------------------
module drd_rank (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  drd_pkg::rank_s2_t           rank_s2,
	input  logic [drd_pkg::VALUE_W-1:0] conf_threshold,
	input  logic [drd_pkg::GAIN_W-1:0]  inv_gain,
	output drd_pkg::box_s3_t            box_s3
);

	logic [drd_pkg::VALUE_W-1:0] best_q;
	logic [drd_pkg::CLASS_W-1:0] best_class_q;
	logic [drd_pkg::VALUE_W-1:0] score_sat;
	logic                        take;
	logic [drd_pkg::VALUE_W-1:0] best_next;
	logic [drd_pkg::CLASS_W-1:0] class_next;

	// Truncate the Q20.28 product to Q10.14 and saturate; compare with the best.
	always_comb begin
		if (rank_s2.prod[drd_pkg::PROD_W-1:drd_pkg::FRAC_W+drd_pkg::VALUE_W] != '0) begin
			score_sat = '1;
		end else begin
			score_sat = rank_s2.prod[drd_pkg::FRAC_W+drd_pkg::VALUE_W-1:drd_pkg::FRAC_W];
		end
		take       = rank_s2.first || (score_sat > best_q);
		best_next  = take ? score_sat : best_q;
		class_next = take ? rank_s2.class_idx : best_class_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q       <= '0;
			best_class_q <= '0;
		end else if (advance && rank_s2.valid) begin
			best_q       <= best_next;
			best_class_q <= class_next;
		end
	end

	// Stage 3 register: result flag, score and the four scaling products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_s3 <= '0;
		end else if (advance) begin
			box_s3.result    <= rank_s2.valid && rank_s2.last && rank_s2.passes
				&& (best_next > conf_threshold);
			box_s3.neg_x     <= rank_s2.neg_x;
			box_s3.neg_y     <= rank_s2.neg_y;
			box_s3.prod_x    <= drd_pkg::CPROD_W'(rank_s2.mag_x) * drd_pkg::CPROD_W'(inv_gain);
			box_s3.prod_y    <= drd_pkg::CPROD_W'(rank_s2.mag_y) * drd_pkg::CPROD_W'(inv_gain);
			box_s3.prod_w    <= drd_pkg::EPROD_W'(rank_s2.size_w) * drd_pkg::EPROD_W'(inv_gain);
			box_s3.prod_h    <= drd_pkg::EPROD_W'(rank_s2.size_h) * drd_pkg::EPROD_W'(inv_gain);
			box_s3.score     <= best_next;
			box_s3.class_idx <= class_next;
		end
	end

endmodule

[src/drd_out.sv]
// ----------------------------------------------------------------------------
// drd_out: final scaling, saturation and output register
// Shifts the scaling products down to pixels, saturates them, and holds the
// box until the master side takes it. It also makes the pipeline advance.
// ----------------------------------------------------------------------------
module drd_out (
	input  logic                      clk,
	input  logic                      arst_n,
	input  drd_pkg::box_s3_t          box_s3,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [drd_pkg::OUT_W-1:0] box_data,
	output logic                      advance
);

	localparam int CQ_W = drd_pkg::CPROD_W - drd_pkg::CSHIFT;
	localparam int EQ_W = drd_pkg::EPROD_W - drd_pkg::ESHIFT;

	logic [CQ_W-1:0]              q_x;
	logic [CQ_W-1:0]              q_y;
	logic [EQ_W-1:0]              q_w;
	logic [EQ_W-1:0]              q_h;
	logic [drd_pkg::EDGE_W-1:0]   left;
	logic [drd_pkg::EDGE_W-1:0]   top;
	logic [drd_pkg::EDGE_W-1:0]   box_width;
	logic [drd_pkg::EDGE_W-1:0]   box_height;
	logic                         out_valid_q;
	logic [drd_pkg::OUT_W-1:0]    box_data_q;

	// Returns a saturated signed edge from a sign and a truncated magnitude.
	function automatic logic [drd_pkg::EDGE_W-1:0] edge_sat(input logic neg,
			input logic [CQ_W-1:0] q);
		logic [16:0] q_ext;
		q_ext = 17'(q);
		if (neg) begin
			edge_sat = (q_ext > drd_pkg::EDGE_NEG_MAX) ? 16'h8000 : 16'(17'd0 - q_ext);
		end else begin
			edge_sat = (q_ext > drd_pkg::EDGE_POS_MAX) ? 16'h7FFF : 16'(q_ext);
		end
	endfunction

	// Returns a saturated unsigned size.
	function automatic logic [drd_pkg::EDGE_W-1:0] size_sat(input logic [EQ_W-1:0] q);
		logic [16:0] q_ext;
		q_ext = 17'(q);
		size_sat = (q_ext > drd_pkg::SIZE_MAX) ? 16'hFFFF : 16'(q_ext);
	endfunction

	// Scale down and saturate.
	always_comb begin
		q_x        = box_s3.prod_x[drd_pkg::CPROD_W-1:drd_pkg::CSHIFT];
		q_y        = box_s3.prod_y[drd_pkg::CPROD_W-1:drd_pkg::CSHIFT];
		q_w        = box_s3.prod_w[drd_pkg::EPROD_W-1:drd_pkg::ESHIFT];
		q_h        = box_s3.prod_h[drd_pkg::EPROD_W-1:drd_pkg::ESHIFT];
		left       = edge_sat(box_s3.neg_x, q_x);
		top        = edge_sat(box_s3.neg_y, q_y);
		box_width  = size_sat(q_w);
		box_height = size_sat(q_h);
	end

	// The pipeline halts only when a box is ready and the output is still full.
	assign advance = !(box_s3.result && out_valid_q && !out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && box_s3.result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && box_s3.result) begin
			box_data_q <= {1'b0, box_s3.class_idx, box_s3.score,
				box_height, box_width, top, left};
		end
	end

	assign out_valid = out_valid_q;
	assign box_data  = box_data_q;

endmodule

[src/detection_row_decode_core.sv]
// ----------------------------------------------------------------------------
// detection_row_decode_core: detector output row decoder
// Decodes rows of cx, cy, w, h, objectness and class scores into boxes.
//
//   Channel  Direction  Handshake            Payload
//   s_*      in         s_tvalid / s_tready  s_tdata: value
//   m_*      out        m_tvalid / m_tready  m_tdata: box fields, score, class
//   cfg_*    in         cfg_we               cfg_index, cfg_data
//
// One value is taken in every cycle. A box is offered once the last class value
// of its row has passed the input register, product stage, ranking stage and
// output register. Reset loads the default registers and starts a new row.
// The input is held off only while a finished box waits in the ranking stage
// and the output register is still full and stalled.
// ----------------------------------------------------------------------------
module detection_row_decode_core #(
	parameter int MAX_CLASSES = drd_pkg::MAX_CLASSES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Stream input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [23:0]                     s_tdata,   // [23:0] value
	// Stream output
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [drd_pkg::OUT_W-1:0]       m_tdata,   // [15:0] left, [31:16] top,
	                                                   // [47:32] box_width,
	                                                   // [63:48] box_height,
	                                                   // [87:64] score,
	                                                   // [94:88] class_id, [95] zero
	// Configuration write port
	input  logic                            cfg_we,
	input  logic [drd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [drd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [drd_pkg::COUNT_W-1:0] class_count_q;
	logic [drd_pkg::VALUE_W-1:0] conf_threshold_q;
	logic [drd_pkg::GAIN_W-1:0]  inv_gain_q;
	logic                        advance;
	drd_pkg::rank_s2_t           rank_s2;
	drd_pkg::box_s3_t            box_s3;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q    <= drd_pkg::CLASS_COUNT_RST;
			conf_threshold_q <= drd_pkg::CONF_THRESHOLD_RST;
			inv_gain_q       <= drd_pkg::INV_GAIN_RST;
		end else if (cfg_we) begin
			case (drd_pkg::cfg_index_t'(cfg_index))
				drd_pkg::CFG_CLASS_COUNT: begin
					class_count_q <= cfg_data[drd_pkg::COUNT_W-1:0];
				end
				drd_pkg::CFG_CONF_THRESHOLD: begin
					conf_threshold_q <= cfg_data[drd_pkg::VALUE_W-1:0];
				end
				drd_pkg::CFG_INV_GAIN: begin
					inv_gain_q <= cfg_data[drd_pkg::GAIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign s_tready = advance;

	drd_front #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.in_valid      (s_tvalid),
		.in_value      (s_tdata),
		.class_count   (class_count_q),
		.conf_threshold(conf_threshold_q),
		.rank_s2       (rank_s2)
	);

	drd_rank u_rank (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.rank_s2       (rank_s2),
		.conf_threshold(conf_threshold_q),
		.inv_gain      (inv_gain_q),
		.box_s3        (box_s3)
	);

	drd_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.box_s3   (box_s3),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.box_data (m_tdata),
		.advance  (advance)
	);

endmodule
